FILE: rtl/lgw_pkg.sv
// Shared types and constants for the Lissajous gradient waveform block.
`timescale 1ns / 1ps
package lgw_pkg;

   localparam int DUR_W      = 24;
   localparam int TURN_W     = 20;
   localparam int KRAD_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int OUT_W      = 48;

   localparam int TERMS   = 12;
   localparam int T_W     = 31;
   localparam int X_W     = 30;
   localparam int SC_W    = 33;
   localparam int RCP_W   = 34;
   localparam int RCP_SHIFT = 33;

   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [T_W-1:0] ONE_T = T_W'(1) << 30;
   localparam logic signed [SC_W-1:0] ONE_SC = SC_W'(1) << 30;

   localparam logic [RCP_W-1:0] RCP_NUM = RCP_W'(1) << RCP_SHIFT;
   localparam logic [RCP_W-1:0] RECIP_TAB [0:TERMS] = '{
      RCP_W'(0),        RCP_NUM / 34'd1,  RCP_NUM / 34'd2,  RCP_NUM / 34'd3,
      RCP_NUM / 34'd4,  RCP_NUM / 34'd5,  RCP_NUM / 34'd6,  RCP_NUM / 34'd7,
      RCP_NUM / 34'd8,  RCP_NUM / 34'd9,  RCP_NUM / 34'd10, RCP_NUM / 34'd11,
      RCP_NUM / 34'd12
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS, CSR_DURATION, CSR_RADIAL, CSR_AZIMUTH, CSR_KRADIUS
   } csr_index_type;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic       mirror;
      logic [1:0] quad;
   } sc_ctl_type;

endpackage

FILE: rtl/lissajous_gradient_waveform.sv
// Top level: Lissajous gradient waveform sample pipeline.
// Throughput: one request per cycle; busy stays low. Latency is set by the divider
// cell rows (one quotient bit per cycle) and the Taylor cell row.
// Reset: synchronous; configuration registers return to defaults and in-flight requests are dropped.
// The receiver cannot stall: each result is shown for one cycle with rsp_valid.
`timescale 1ns / 1ps
module lissajous_gradient_waveform #(
   parameter int TIME_BITS    = 24,
   parameter int ANGLE_STAGES = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [lgw_pkg::DUR_W-1:0]             req_sample_time,
   output logic                                  rsp_valid,
   output logic signed [lgw_pkg::OUT_W-1:0]      rsp_gradient_value,
   input  logic                                  csr_we,
   input  logic [lgw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lgw_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import lgw_pkg::*;

   localparam int MASK_BITS = (TIME_BITS < DUR_W) ? TIME_BITS : DUR_W;
   localparam logic [DUR_W-1:0] TIME_MASK = {DUR_W{1'b1}} >> (DUR_W - MASK_BITS);
   localparam int N_W       = TURN_W + DUR_W;
   localparam int PH_W      = N_W + 24;
   localparam int PH_CELLS  = PH_W - (32 - ANGLE_STAGES);
   localparam int SC_LAT    = 2 + 3 * TERMS;
   localparam int SUM_W     = 53;
   localparam int MAG_W     = 51;
   localparam int DIV_W     = MAG_W - 7;
   localparam int LAT       = 2 + PH_CELLS + SC_LAT + 5 + DIV_W + 1;

   function automatic logic [31:0] mag32(input logic signed [SC_W-1:0] v);
      logic signed [SC_W-1:0] a;
      a = v[SC_W-1] ? -v : v;
      return a[31:0];
   endfunction

   // configuration
   logic [1:0]        axis_ff;
   logic [DUR_W-1:0]  duration_ff;
   logic [TURN_W-1:0] radial_ff, azimuth_ff;
   logic [KRAD_W-1:0] kradius_ff;
   logic [DUR_W-1:0]  dur_masked, dur_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff     <= AXIS_X;
         duration_ff <= DUR_W'(1);
         radial_ff   <= TURN_W'(5120);
         azimuth_ff  <= TURN_W'(5376);
         kradius_ff  <= KRAD_W'(838861);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AXIS:     axis_ff     <= csr_wdata[1:0];
            CSR_DURATION: duration_ff <= csr_wdata[DUR_W-1:0];
            CSR_RADIAL:   radial_ff   <= csr_wdata[TURN_W-1:0];
            CSR_AZIMUTH:  azimuth_ff  <= csr_wdata[TURN_W-1:0];
            CSR_KRADIUS:  kradius_ff  <= csr_wdata[KRAD_W-1:0];
            default: ;
         endcase
      end
   end

   assign dur_masked = duration_ff & TIME_MASK;
   assign dur_eff    = (dur_masked == '0) ? DUR_W'(1) : dur_masked;

   // request handshake and valid line
   logic           req_accept;
   logic [LAT-1:0] valid_in, valid_ff;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;
   assign valid_in   = {valid_ff[LAT-2:0], req_accept};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   // time sample and turn products
   logic [DUR_W-1:0] tm_ff;
   logic [N_W-1:0]   nr_in, na_in, nr_ff, na_ff;

   assign nr_in = N_W'(radial_ff) * N_W'(tm_ff);
   assign na_in = N_W'(azimuth_ff) * N_W'(tm_ff);

   always_ff @(posedge clock) begin
      tm_ff <= req_sample_time & TIME_MASK;
      nr_ff <= nr_in;
      na_ff <= na_in;
   end

   // phase division rows
   logic [PH_W-1:0] wr, wa;
   logic [31:0]     phase_r, phase_a;

   lgw_div_chain #(.W(PH_W), .CELLS(PH_CELLS)) u_div_rad (
      .clock (clock), .divisor (dur_eff), .dividend ({nr_ff, 24'b0}), .work_out (wr)
   );
   lgw_div_chain #(.W(PH_W), .CELLS(PH_CELLS)) u_div_azi (
      .clock (clock), .divisor (dur_eff), .dividend ({na_ff, 24'b0}), .work_out (wa)
   );

   assign phase_r = 32'(wr[ANGLE_STAGES-1:0]) << (32 - ANGLE_STAGES);
   assign phase_a = 32'(wa[ANGLE_STAGES-1:0]) << (32 - ANGLE_STAGES);

   logic signed [SC_W-1:0] sr, cr, sp, cp;

   lgw_sincos u_sc_rad (.clock (clock), .phase (phase_r), .sin_o (sr), .cos_o (cr));
   lgw_sincos u_sc_azi (.clock (clock), .phase (phase_a), .sin_o (sp), .cos_o (cp));

   // Q30 products, turn scaling, axis combine
   logic signed [SC_W-1:0] a1, b1, a2, b2;
   logic [63:0]            p1m_in, p2m_in, p1m_ff, p2m_ff;
   logic                   n1_ff, n2_ff;
   logic signed [31:0]     m1, m2;
   logic signed [SUM_W-1:0] t1_in, t2_in, t1_ff, t2_ff, sum_in, sum_ff;

   always_comb begin
      a1 = cr;
      b1 = (axis_ff == AXIS_Y) ? sp : cp;
      a2 = sr;
      b2 = (axis_ff == AXIS_Y) ? cp : sp;
      if (axis_ff == AXIS_Z) begin
         a1 = sr;
         b1 = ONE_SC;
      end
      p1m_in = 64'(mag32(a1)) * 64'(mag32(b1));
      p2m_in = 64'(mag32(a2)) * 64'(mag32(b2));
      m1 = n1_ff ? -$signed({1'b0, p1m_ff[60:30]}) : $signed({1'b0, p1m_ff[60:30]});
      m2 = n2_ff ? -$signed({1'b0, p2m_ff[60:30]}) : $signed({1'b0, p2m_ff[60:30]});
      t1_in = SUM_W'($signed({1'b0, radial_ff})) * SUM_W'(m1);
      t2_in = SUM_W'($signed({1'b0, azimuth_ff})) * SUM_W'(m2);
      unique case (axis_ff)
         AXIS_X:  sum_in = t1_ff - t2_ff;
         AXIS_Y:  sum_in = t1_ff + t2_ff;
         AXIS_Z:  sum_in = -t1_ff;
         default: sum_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      p1m_ff <= p1m_in;
      p2m_ff <= p2m_in;
      n1_ff  <= a1[SC_W-1] ^ b1[SC_W-1];
      n2_ff  <= a2[SC_W-1] ^ b2[SC_W-1];
      t1_ff  <= t1_in;
      t2_ff  <= t2_in;
      sum_ff <= sum_in;
   end

   // radius scaling
   logic signed [SUM_W-1:0] sum_abs;
   logic [MAG_W-1:0]        mag;
   logic [63:0]             plo_in, plo_ff;
   logic [MAG_W-1:0]        phi_in, phi_ff;
   logic                    neg_ff, negd_ff;
   logic [MAG_W:0]          xs;
   logic [DIV_W-1:0]        dvd_ff;

   always_comb begin
      sum_abs = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
      mag     = sum_abs[MAG_W-1:0];
      plo_in  = 64'(kradius_ff) * 64'(mag[31:0]);
      phi_in  = MAG_W'(kradius_ff) * MAG_W'(mag[MAG_W-1:32]);
      xs      = (MAG_W+1)'(plo_ff[63:32]) + (MAG_W+1)'(phi_ff);
   end

   always_ff @(posedge clock) begin
      neg_ff  <= sum_ff[SUM_W-1];
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      negd_ff <= neg_ff;
      dvd_ff  <= xs[MAG_W-1:7];
   end

   // amplitude division row
   logic [DIV_W-1:0] quo;
   logic             neg_line [0:DIV_W-1];

   lgw_div_chain #(.W(DIV_W), .CELLS(DIV_W)) u_div_out (
      .clock (clock), .divisor (dur_eff), .dividend (dvd_ff), .work_out (quo)
   );

   always_ff @(posedge clock) begin
      neg_line[0] <= negd_ff;
      for (int i = 1; i < DIV_W; i++) neg_line[i] <= neg_line[i-1];
   end

   logic signed [OUT_W-1:0] grad_in, grad_ff;

   assign grad_in = neg_line[DIV_W-1] ? -$signed(OUT_W'(quo)) : $signed(OUT_W'(quo));

   always_ff @(posedge clock) begin
      grad_ff <= grad_in;
   end

   assign rsp_valid          = valid_ff[LAT-1];
   assign rsp_gradient_value = grad_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##LAT rsp_valid)
      else $error("request did not produce a response after the pipeline latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, LAT))
      else $error("response without a matching request");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gradient_value[OUT_W-1:DIV_W] == '0 ||
                     rsp_gradient_value[OUT_W-1:DIV_W] == '1))
      else $error("gradient magnitude exceeds divider width");
endmodule

FILE: rtl/lgw_div_cell.sv
// One restoring-division cell: consumes one dividend bit, emits one quotient bit.
`timescale 1ns / 1ps
module lgw_div_cell #(
   parameter int W = 8
) (
   input  logic                      clock,
   input  logic [lgw_pkg::DUR_W-1:0] divisor,
   input  logic [lgw_pkg::DUR_W-1:0] rem_i,
   input  logic [W-1:0]              work_i,
   output logic [lgw_pkg::DUR_W-1:0] rem_o,
   output logic [W-1:0]              work_o
);
   import lgw_pkg::*;

   logic [DUR_W:0]   trial;
   logic             take;
   logic [DUR_W-1:0] rem_in, rem_ff;
   logic [W-1:0]     work_in, work_ff;

   always_comb begin
      trial   = {rem_i, work_i[W-1]};
      take    = trial >= {1'b0, divisor};
      rem_in  = take ? DUR_W'(trial - {1'b0, divisor}) : trial[DUR_W-1:0];
      work_in = {work_i[W-2:0], take};
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      work_ff <= work_in;
   end

   assign rem_o  = rem_ff;
   assign work_o = work_ff;
endmodule

FILE: rtl/lgw_div_chain.sv
// Row of division cells; the low CELLS bits of the result hold the quotient.
`timescale 1ns / 1ps
module lgw_div_chain #(
   parameter int W     = 8,
   parameter int CELLS = 8
) (
   input  logic                      clock,
   input  logic [lgw_pkg::DUR_W-1:0] divisor,
   input  logic [W-1:0]              dividend,
   output logic [W-1:0]              work_out
);
   import lgw_pkg::*;

   logic [DUR_W-1:0] rem_w  [0:CELLS];
   logic [W-1:0]     work_w [0:CELLS];

   assign rem_w[0]  = '0;
   assign work_w[0] = dividend;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      lgw_div_cell #(.W(W)) u_cell (
         .clock   (clock),
         .divisor (divisor),
         .rem_i   (rem_w[i]),
         .work_i  (work_w[i]),
         .rem_o   (rem_w[i+1]),
         .work_o  (work_w[i+1])
      );
   end

   assign work_out = work_w[CELLS];
endmodule

FILE: rtl/lgw_taylor_cell.sv
// One Taylor term cell: t = floor(t*x/2^30)/K, folded into sine or cosine sum.
`timescale 1ns / 1ps
module lgw_taylor_cell #(
   parameter int K = 1
) (
   input  logic                            clock,
   input  logic [lgw_pkg::X_W-1:0]         x_i,
   input  logic [lgw_pkg::T_W-1:0]         t_i,
   input  logic signed [lgw_pkg::SC_W-1:0] s_i,
   input  logic signed [lgw_pkg::SC_W-1:0] c_i,
   input  lgw_pkg::sc_ctl_type             ctl_i,
   output logic [lgw_pkg::X_W-1:0]         x_o,
   output logic [lgw_pkg::T_W-1:0]         t_o,
   output logic signed [lgw_pkg::SC_W-1:0] s_o,
   output logic signed [lgw_pkg::SC_W-1:0] c_o,
   output lgw_pkg::sc_ctl_type             ctl_o
);
   import lgw_pkg::*;

   localparam logic [RCP_W-1:0] RCP = RECIP_TAB[K];
   localparam logic [3:0] K_L = 4'(K);
   localparam int K_MOD = K % 4;
   localparam int BW = T_W + 4;

   // stage 1: product
   logic [T_W+X_W-1:0] prod_in, prod_ff;
   logic [X_W-1:0]     x1_ff;
   logic signed [SC_W-1:0] s1_ff, c1_ff;
   sc_ctl_type         ctl1_ff;
   // stage 2: reciprocal estimate
   logic [T_W+RCP_W-1:0] scaled;
   logic [T_W-1:0]     u_in, u2_ff, qe_in, qe2_ff;
   logic [X_W-1:0]     x2_ff;
   logic signed [SC_W-1:0] s2_ff, c2_ff;
   sc_ctl_type         ctl2_ff;
   // stage 3: correction and accumulate
   logic [BW-1:0]      back, rdiff;
   logic               bump;
   logic [T_W-1:0]     q_in, t_ff;
   logic signed [SC_W-1:0] q_ext, s_in, c_in, s_ff, c_ff;
   logic [X_W-1:0]     x_ff;
   sc_ctl_type         ctl_ff;

   always_comb begin
      prod_in = {{X_W{1'b0}}, t_i} * {{T_W{1'b0}}, x_i};
      u_in    = prod_ff[T_W+X_W-1:X_W];
      scaled  = {{RCP_W{1'b0}}, u_in} * {{T_W{1'b0}}, RCP};
      qe_in   = scaled[RCP_SHIFT+T_W-1:RCP_SHIFT];
      back    = BW'(qe2_ff) * BW'(K_L);
      rdiff   = BW'(u2_ff) - back;
      bump    = rdiff >= BW'(K_L);
      q_in    = qe2_ff + T_W'(bump);
      q_ext   = $signed({{(SC_W-T_W){1'b0}}, q_in});
      s_in    = s2_ff;
      c_in    = c2_ff;
      case (K_MOD)
         1:       s_in = s2_ff + q_ext;
         3:       s_in = s2_ff - q_ext;
         2:       c_in = c2_ff - q_ext;
         default: c_in = c2_ff + q_ext;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      x1_ff   <= x_i;
      s1_ff   <= s_i;
      c1_ff   <= c_i;
      ctl1_ff <= ctl_i;
      u2_ff   <= u_in;
      qe2_ff  <= qe_in;
      x2_ff   <= x1_ff;
      s2_ff   <= s1_ff;
      c2_ff   <= c1_ff;
      ctl2_ff <= ctl1_ff;
      t_ff    <= q_in;
      s_ff    <= s_in;
      c_ff    <= c_in;
      x_ff    <= x2_ff;
      ctl_ff  <= ctl2_ff;
   end

   assign x_o   = x_ff;
   assign t_o   = t_ff;
   assign s_o   = s_ff;
   assign c_o   = c_ff;
   assign ctl_o = ctl_ff;
endmodule

FILE: rtl/lgw_sincos.sv
// Pipelined sine/cosine of a Q0.32 phase: octant fold, Taylor cell row, unfold.
`timescale 1ns / 1ps
module lgw_sincos (
   input  logic                            clock,
   input  logic [31:0]                     phase,
   output logic signed [lgw_pkg::SC_W-1:0] sin_o,
   output logic signed [lgw_pkg::SC_W-1:0] cos_o
);
   import lgw_pkg::*;

   logic [29:0]      frac, g;
   logic             mirror;
   logic [61:0]      xprod;
   logic [X_W-1:0]   x_in, x_ff;
   sc_ctl_type       ctl_in, ctl_ff;

   logic [X_W-1:0]         x_w   [0:TERMS];
   logic [T_W-1:0]         t_w   [0:TERMS];
   logic signed [SC_W-1:0] s_w   [0:TERMS];
   logic signed [SC_W-1:0] c_w   [0:TERMS];
   sc_ctl_type             ctl_w [0:TERMS];

   logic signed [SC_W-1:0] ss, cc, sin_in, cos_in, sin_ff, cos_ff;

   always_comb begin
      frac   = phase[29:0];
      mirror = frac > 30'h2000_0000;
      g      = mirror ? 30'h0 - frac : frac;
      xprod  = {32'b0, g} * {30'b0, PI_Q30};
      x_in   = xprod[60:31];
      ctl_in = '{mirror: mirror, quad: phase[31:30]};
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      ctl_ff <= ctl_in;
   end

   assign x_w[0]   = x_ff;
   assign t_w[0]   = ONE_T;
   assign s_w[0]   = '0;
   assign c_w[0]   = ONE_SC;
   assign ctl_w[0] = ctl_ff;

   for (genvar i = 0; i < TERMS; i++) begin : g_term
      lgw_taylor_cell #(.K(i + 1)) u_term (
         .clock (clock),
         .x_i   (x_w[i]),
         .t_i   (t_w[i]),
         .s_i   (s_w[i]),
         .c_i   (c_w[i]),
         .ctl_i (ctl_w[i]),
         .x_o   (x_w[i+1]),
         .t_o   (t_w[i+1]),
         .s_o   (s_w[i+1]),
         .c_o   (c_w[i+1]),
         .ctl_o (ctl_w[i+1])
      );
   end

   always_comb begin
      ss = ctl_w[TERMS].mirror ? c_w[TERMS] : s_w[TERMS];
      cc = ctl_w[TERMS].mirror ? s_w[TERMS] : c_w[TERMS];
      case (ctl_w[TERMS].quad)
         2'd0:    begin sin_in = ss;  cos_in = cc;  end
         2'd1:    begin sin_in = cc;  cos_in = -ss; end
         2'd2:    begin sin_in = -ss; cos_in = -cc; end
         default: begin sin_in = -cc; cos_in = ss;  end
      endcase
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;
endmodule

FILE: tb/sv/lissajous_gradient_waveform_tb.sv
// Self-checking testbench for the Lissajous gradient waveform pipeline.
`timescale 1ns / 1ps
module lissajous_gradient_waveform_tb;
   import lgw_pkg::*;

   localparam int LATENCY  = 146;
   localparam int WATCHDOG = 2000;
   localparam int N_RANDOM = 630;
   localparam int ANGLE_STAGES = 20;
   localparam logic [63:0] PI_FIX  = 64'd3373259426;
   localparam longint      OUT_TOP = (longint'(1) << 47) - 1;

   typedef struct {
      logic [23:0] sample_time;
      logic        has_known;
      logic [47:0] known;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [DUR_W-1:0]         req_sample_time = '0;
   logic                     rsp_valid;
   logic signed [OUT_W-1:0]  rsp_gradient_value;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   logic [1:0]  cfg_axis;
   logic [23:0] cfg_dur;
   logic [19:0] cfg_rho;
   logic [19:0] cfg_phi;
   logic [31:0] cfg_krad;

   logic [47:0] gradient_queue[$];
   int          errors = 0;
   int          idle_cycles = 0;
   stim_row_type stim_table[$];

   lissajous_gradient_waveform uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] turn_phase(logic [63:0] turns, logic [63:0] tm,
                                              logic [63:0] dur);
      logic [63:0] r;
      logic [63:0] p;
      r = (turns * tm) % (dur << 8);
      p = (r << 24) / dur;
      return (p[31:0] >> (32 - ANGLE_STAGES)) << (32 - ANGLE_STAGES);
   endfunction

   function automatic void sine_cosine(input logic [31:0] ph, output longint s_o,
                                       output longint c_o);
      logic [1:0]  quad;
      logic [63:0] f;
      logic [63:0] g;
      logic [63:0] x;
      logic [63:0] t;
      logic        mirror;
      longint      s;
      longint      c;
      longint      tmp;
      quad = ph[31:30];
      f = {34'd0, ph[29:0]};
      mirror = f > 64'h2000_0000;
      g = mirror ? 64'h4000_0000 - f : f;
      x = (g * PI_FIX) >> 31;
      t = 64'h4000_0000;
      s = 0;
      c = longint'(1) << 30;
      for (int k = 1; k <= 12; k++) begin
         t = ((t * x) >> 30) / k;
         if (k % 2 == 1) s += (k % 4 == 1) ? longint'(t) : -longint'(t);
         else c += (k % 4 == 0) ? longint'(t) : -longint'(t);
      end
      if (mirror) begin
         tmp = s; s = c; c = tmp;
      end
      case (quad)
         2'd0: begin s_o = s; c_o = c; end
         2'd1: begin s_o = c; c_o = -s; end
         2'd2: begin s_o = -s; c_o = -c; end
         default: begin s_o = -c; c_o = s; end
      endcase
   endfunction

   function automatic longint product_q30(longint a, longint b);
      logic        neg;
      logic [63:0] m;
      neg = (a < 0) != (b < 0);
      m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >> 30;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [47:0] predict_gradient(logic [23:0] tm);
      logic [63:0] dur;
      longint      sr, cr, sp, cp, total, res;
      logic [63:0] mag, lo_part, hi_part;
      logic        neg;
      dur = (cfg_dur == 0) ? 64'd1 : {40'd0, cfg_dur};
      sine_cosine(turn_phase(cfg_rho, tm, dur), sr, cr);
      sine_cosine(turn_phase(cfg_phi, tm, dur), sp, cp);
      case (cfg_axis)
         AXIS_X: total = longint'(cfg_rho) * product_q30(cr, cp)
                       - longint'(cfg_phi) * product_q30(sr, sp);
         AXIS_Y: total = longint'(cfg_rho) * product_q30(cr, sp)
                       + longint'(cfg_phi) * product_q30(sr, cp);
         AXIS_Z: total = -(longint'(cfg_rho) * sr);
         default: total = 0;
      endcase
      neg = total < 0;
      mag = neg ? -total : total;
      lo_part = (64'(cfg_krad) * mag[31:0]) >> 32;
      hi_part = 64'(cfg_krad) * (mag >> 32);
      mag = ((lo_part + hi_part) >> 7) / dur;
      if (neg) res = (mag > OUT_TOP + 1) ? -OUT_TOP - 1 : -longint'(mag);
      else res = (mag > OUT_TOP) ? OUT_TOP : longint'(mag);
      return res[47:0];
   endfunction

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AXIS:     cfg_axis = value[1:0];
         CSR_DURATION: cfg_dur = value[23:0];
         CSR_RADIAL:   cfg_rho = value[19:0];
         CSR_AZIMUTH:  cfg_phi = value[19:0];
         CSR_KRADIUS:  cfg_krad = value;
         default: ;
      endcase
   endtask

   task automatic send_sample(logic [23:0] tm, logic has_known, logic [47:0] known);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 1) == 0) gap = 0;
      if (gap != 0) start <= 1'b0;
      repeat (gap) @(negedge clock);
      start <= 1'b1;
      req_sample_time <= tm;
      @(posedge clock);
      while (busy) @(posedge clock);
      gradient_queue.push_back(has_known ? known : predict_gradient(tm));
      @(negedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (gradient_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   function automatic logic [23:0] random_time;
      case ($urandom_range(0, 5))
         0: return 24'hFF_FFFF;
         1: return 24'd0;
         2: return 24'($urandom_range(0, 2 * cfg_dur + 1));
         default: return 24'($urandom_range(0, cfg_dur));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset || !(start && !busy) && !rsp_valid) idle_cycles <= idle_cycles + 1;
      else idle_cycles <= 0;
      if (!reset && idle_cycles > WATCHDOG) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (gradient_queue.size() == 0) begin
            $error("gradient_value: unexpected result %h", rsp_gradient_value);
            errors++;
         end else begin
            if (gradient_queue[0] !== rsp_gradient_value) begin
               $error("gradient_value: expected %h actual %h", gradient_queue[0],
                      rsp_gradient_value);
               errors++;
            end
            gradient_queue.pop_front();
         end
      end
   end

   initial begin
      cfg_axis = AXIS_X;
      cfg_dur = 24'd1;
      cfg_rho = 20'd5120;
      cfg_phi = 20'd5376;
      cfg_krad = 32'd838861;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default setup: duration 1, integer turns, every time wraps to phase zero
      stim_table.push_back('{24'd0, 1'b1, 48'd8388610});
      stim_table.push_back('{24'hFF_FFFF, 1'b1, 48'd8388610});
      stim_table.push_back('{24'h80_0000, 1'b0, 48'd0});
      foreach (stim_table[i])
         send_sample(stim_table[i].sample_time, stim_table[i].has_known,
                     stim_table[i].known);
      drain();

      // zero duration acts as one; Z at phase zero gives zero
      write_csr(CSR_DURATION, 32'd0);
      write_csr(CSR_AXIS, {30'd0, AXIS_Z});
      send_sample(24'd7, 1'b1, 48'd0);
      drain();
      // unused axis code
      write_csr(CSR_AXIS, 32'd3);
      send_sample(24'd3, 1'b1, 48'd0);
      drain();

      // extremes: maximal radius and turns
      write_csr(CSR_AXIS, {30'd0, AXIS_Y});
      write_csr(CSR_DURATION, 32'd1000);
      write_csr(CSR_RADIAL, 32'hF_FFFF);
      write_csr(CSR_AZIMUTH, 32'hF_FFFF);
      write_csr(CSR_KRADIUS, 32'hFFFF_FFFF);
      for (int i = 0; i < 8; i++) send_sample(random_time(), 1'b0, '0);
      drain();
      write_csr(CSR_AXIS, {30'd0, AXIS_X});
      write_csr(CSR_DURATION, 32'hFF_FFFF);
      write_csr(CSR_RADIAL, 32'd0);
      write_csr(CSR_AZIMUTH, 32'd1);
      for (int i = 0; i < 6; i++) send_sample(random_time(), 1'b0, '0);
      drain();

      for (int phase = 0; phase < 14; phase++) begin
         write_csr(CSR_AXIS, $urandom_range(0, 3));
         write_csr(CSR_DURATION, (phase % 4 == 0) ? $urandom_range(1, 24'hFF_FFFF)
                                                  : $urandom_range(1, 5000));
         write_csr(CSR_RADIAL, (phase % 5 == 0) ? $urandom_range(0, 20'hF_FFFF)
                                                : $urandom_range(0, 8192));
         write_csr(CSR_AZIMUTH, (phase % 5 == 1) ? $urandom_range(0, 20'hF_FFFF)
                                                 : $urandom_range(0, 8192));
         write_csr(CSR_KRADIUS, (phase % 3 == 0) ? $urandom() : $urandom_range(0, 1 << 24));
         if (phase % 6 == 5) write_csr(csr_index_type'(3'd7), $urandom());
         for (int i = 0; i < N_RANDOM / 14; i++) send_sample(random_time(), 1'b0, '0);
         drain();
      end

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
